>>> hw/rtl/dual_card_dispenser_sequencer_top_macros.svh
// ----------------------------------------------------------------------------
// Dual card dispenser sequencer assertion macros
// Shared concurrent assertion forms for the sequencer RTL
// ----------------------------------------------------------------------------
`ifndef DUAL_CARD_DISPENSER_SEQUENCER_TOP_MACROS_SVH
`define DUAL_CARD_DISPENSER_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define DCDS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define DCDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/dcds_pkg.sv
// ----------------------------------------------------------------------------
// Dual card dispenser sequencer package
// Types, codes and register defaults shared by the sequencer modules
// ----------------------------------------------------------------------------
package dcds_pkg;

    localparam int unsigned MS_W = 16;

    typedef logic [MS_W-1:0] t_ms;

    // register defaults in milliseconds
    localparam t_ms PULSE_MS_RST          = 16'd500;
    localparam t_ms CALLBACK_PULSE_MS_RST = 16'd300;
    localparam t_ms PAYOUT_WINDOW_MS_RST  = 16'd30000;
    localparam t_ms PLACE_TIMEOUT_MS_RST  = 16'd10000;
    localparam t_ms TAKE_TIMEOUT_MS_RST   = 16'd45000;
    localparam t_ms ERROR_CHECK_MS_RST    = 16'd3000;
    localparam t_ms LOW_STOCK_WAIT_MS_RST = 16'd5000;
    localparam t_ms NORMAL_WAIT_MS_RST    = 16'd100;

    // configuration register index
    typedef enum logic [2:0] {
        CFG_PULSE          = 3'd0,
        CFG_CALLBACK_PULSE = 3'd1,
        CFG_PAYOUT_WINDOW  = 3'd2,
        CFG_PLACE_TIMEOUT  = 3'd3,
        CFG_TAKE_TIMEOUT   = 3'd4,
        CFG_ERROR_CHECK    = 3'd5,
        CFG_LOW_STOCK_WAIT = 3'd6,
        CFG_NORMAL_WAIT    = 3'd7
    } t_cfg_idx;

    // command codes
    typedef enum logic [2:0] {
        CMD_TICK      = 3'd0,
        CMD_PREPARE   = 3'd1,
        CMD_PAYOUT    = 3'd2,
        CMD_CALLBACK  = 3'd3,
        CMD_RESET_ALL = 3'd4,
        CMD_RESET_ONE = 3'd5,
        CMD_QUERY     = 3'd6
    } t_cmd;

    // unit phase
    typedef enum logic [3:0] {
        PH_IDLE          = 4'd0,
        PH_RESETTING     = 4'd1,
        PH_RESET_WAIT    = 4'd2,
        PH_PREPARING     = 4'd3,
        PH_PREPARE_WAIT  = 4'd4,
        PH_PAYOUT_WINDOW = 4'd5,
        PH_PAYOUT_WAIT   = 4'd6,
        PH_PLACE_WAIT    = 4'd7,
        PH_TAKE_WAIT     = 4'd8,
        PH_CALLBACK      = 4'd9,
        PH_CALLBACK_WAIT = 4'd10,
        PH_STATUS_WAIT   = 4'd11,
        PH_ERROR         = 4'd12
    } t_phase;

    typedef struct packed {
        t_ms pulse_ms;
        t_ms callback_pulse_ms;
        t_ms payout_window_ms;
        t_ms place_timeout_ms;
        t_ms take_timeout_ms;
        t_ms error_check_ms;
        t_ms low_stock_wait_ms;
        t_ms normal_wait_ms;
    } t_cfg;

    typedef struct packed {
        logic callback;
        logic reset;
        logic payout;
    } t_drive;

    // per-unit decoded command
    typedef struct packed {
        logic tick;
        logic prepare;
        logic payout;
        logic callback;
        logic reset_all;
        logic force_idle;
    } t_unit_cmd;

    // per-unit state after the transfer
    typedef struct packed {
        t_phase phase;
        t_drive drive;
        logic   take_ev;
        logic   callback_ev;
    } t_unit_view;

    typedef struct packed {
        logic [2:0] cmd;
        logic       unit;
        logic       empty_a;
        logic       fault_a;
        logic       low_a;
        logic       out_ok_a;
        logic       empty_b;
        logic       fault_b;
        logic       low_b;
        logic       out_ok_b;
    } t_in_item;

    typedef struct packed {
        logic [3:0] phase_a;
        logic [3:0] phase_b;
        logic [1:0] drive_payout;
        logic [1:0] drive_reset;
        logic [1:0] drive_callback;
        logic [1:0] take_card_event;
        logic [1:0] callback_card_event;
        logic       available;
        logic       avail_unit;
    } t_out_item;

endpackage

>>> hw/rtl/dcds_cfg.sv
// ----------------------------------------------------------------------------
// Dual card dispenser configuration registers
// Eight 16-bit millisecond settings behind a plain write port
// ----------------------------------------------------------------------------
module dcds_cfg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  logic [2:0]           i_idx,
    input  dcds_pkg::t_ms        i_data,
    output dcds_pkg::t_cfg       o_cfg
);
    import dcds_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // write decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            case (t_cfg_idx'(i_idx))
                CFG_PULSE:          n_cfg.pulse_ms          = i_data;
                CFG_CALLBACK_PULSE: n_cfg.callback_pulse_ms = i_data;
                CFG_PAYOUT_WINDOW:  n_cfg.payout_window_ms  = i_data;
                CFG_PLACE_TIMEOUT:  n_cfg.place_timeout_ms  = i_data;
                CFG_TAKE_TIMEOUT:   n_cfg.take_timeout_ms   = i_data;
                CFG_ERROR_CHECK:    n_cfg.error_check_ms    = i_data;
                CFG_LOW_STOCK_WAIT: n_cfg.low_stock_wait_ms = i_data;
                CFG_NORMAL_WAIT:    n_cfg.normal_wait_ms    = i_data;
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    // register bank with defaults
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_ms          <= PULSE_MS_RST;
            r_cfg.callback_pulse_ms <= CALLBACK_PULSE_MS_RST;
            r_cfg.payout_window_ms  <= PAYOUT_WINDOW_MS_RST;
            r_cfg.place_timeout_ms  <= PLACE_TIMEOUT_MS_RST;
            r_cfg.take_timeout_ms   <= TAKE_TIMEOUT_MS_RST;
            r_cfg.error_check_ms    <= ERROR_CHECK_MS_RST;
            r_cfg.low_stock_wait_ms <= LOW_STOCK_WAIT_MS_RST;
            r_cfg.normal_wait_ms    <= NORMAL_WAIT_MS_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hw/rtl/dcds_unit.sv
// ----------------------------------------------------------------------------
// Dual card dispenser unit sequencer
// One dispenser: phase machine, one-shot millisecond timer and drive lines
// ----------------------------------------------------------------------------
module dcds_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  dcds_pkg::t_unit_cmd   i_cmd,
    input  dcds_pkg::t_cfg        i_cfg,
    input  logic                  i_fault,
    input  logic                  i_low,
    input  logic                  i_out_ok,
    output dcds_pkg::t_unit_view  o_view
);
    import dcds_pkg::*;

    t_phase r_phase, n_phase;
    t_ms    r_cnt, n_cnt;
    logic   r_run, n_run;
    logic   r_to, n_to;
    logic   r_pend, n_pend;
    t_drive r_drive, n_drive;

    t_ms    tk_cnt;
    logic   tk_run;
    logic   tk_to;
    logic   take_ev;
    logic   cb_ev;

    // timer count down on a tick, fires on reaching zero
    always_comb begin
        tk_cnt = r_cnt;
        tk_run = r_run;
        tk_to  = r_to;
        if (i_cmd.tick && r_run) begin
            if (r_cnt != '0) begin
                tk_cnt = r_cnt - t_ms'(1);
            end
            if (tk_cnt == '0) begin
                tk_run = 1'b0;
                tk_to  = 1'b1;
            end
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_cmd.tick) begin
            case (r_phase)
                PH_IDLE:          if (i_fault) n_phase = PH_ERROR;
                PH_RESETTING:     n_phase = PH_RESET_WAIT;
                PH_RESET_WAIT:    if (tk_to) n_phase = PH_IDLE;
                PH_PREPARING:     n_phase = PH_PREPARE_WAIT;
                PH_PREPARE_WAIT:  if (tk_to) n_phase = PH_PAYOUT_WINDOW;
                PH_PAYOUT_WINDOW: begin
                    if (r_pend) n_phase = PH_PAYOUT_WAIT;
                    else if (tk_to) n_phase = PH_IDLE;
                end
                PH_PAYOUT_WAIT:   if (tk_to) n_phase = PH_PLACE_WAIT;
                PH_PLACE_WAIT: begin
                    if (i_out_ok) n_phase = PH_TAKE_WAIT;
                    else if (tk_to) n_phase = PH_ERROR;
                end
                PH_TAKE_WAIT: begin
                    if (!i_out_ok) n_phase = PH_STATUS_WAIT;
                    else if (tk_to) n_phase = PH_CALLBACK;
                end
                PH_CALLBACK:      n_phase = PH_CALLBACK_WAIT;
                PH_CALLBACK_WAIT: if (tk_to) n_phase = PH_IDLE;
                PH_STATUS_WAIT:   if (tk_to) n_phase = PH_IDLE;
                PH_ERROR:         if (tk_to && !i_fault) n_phase = PH_IDLE;
                default:          n_phase = PH_IDLE;
            endcase
        end else if (i_cmd.prepare) begin
            n_phase = PH_PREPARING;
        end else if (i_cmd.callback) begin
            n_phase = PH_CALLBACK;
        end else if (i_cmd.reset_all) begin
            n_phase = PH_RESETTING;
        end else if (i_cmd.force_idle) begin
            n_phase = PH_IDLE;
        end
    end

    // timer arming, drive lines, payout request and events
    always_comb begin
        n_cnt   = r_cnt;
        n_run   = r_run;
        n_to    = r_to;
        n_pend  = r_pend;
        n_drive = r_drive;
        take_ev = 1'b0;
        cb_ev   = 1'b0;
        if (i_cmd.tick) begin
            n_cnt = tk_cnt;
            n_run = tk_run;
            n_to  = tk_to;
            case (r_phase)
                PH_IDLE: begin
                    if (i_fault) begin
                        n_cnt = i_cfg.error_check_ms; n_run = 1'b1; n_to = 1'b0;
                    end
                end
                PH_RESETTING: begin
                    n_drive.reset = 1'b1;
                    n_cnt = i_cfg.pulse_ms; n_run = 1'b1; n_to = 1'b0;
                end
                PH_RESET_WAIT: begin
                    if (tk_to) n_drive.reset = 1'b0;
                end
                PH_PREPARING: begin
                    n_drive.payout = 1'b1;
                    n_cnt = i_cfg.pulse_ms; n_run = 1'b1; n_to = 1'b0;
                end
                PH_PREPARE_WAIT: begin
                    if (tk_to) begin
                        n_drive.payout = 1'b0;
                        n_cnt = i_cfg.payout_window_ms; n_run = 1'b1; n_to = 1'b0;
                    end
                end
                PH_PAYOUT_WINDOW: begin
                    if (r_pend) begin
                        n_pend         = 1'b0;
                        n_drive.payout = 1'b1;
                        n_cnt = i_cfg.pulse_ms; n_run = 1'b1; n_to = 1'b0;
                    end else if (tk_to) begin
                        n_run = 1'b0; n_to = 1'b0;
                    end
                end
                PH_PAYOUT_WAIT: begin
                    if (tk_to) begin
                        n_drive.payout = 1'b0;
                        n_cnt = i_cfg.place_timeout_ms; n_run = 1'b1; n_to = 1'b0;
                    end
                end
                PH_PLACE_WAIT: begin
                    // a placement timeout still reports a callback even if the card
                    // arrives on the same tick
                    if (tk_to) begin
                        cb_ev = 1'b1;
                        n_cnt = i_cfg.error_check_ms; n_run = 1'b1; n_to = 1'b0;
                    end
                    if (i_out_ok) begin
                        n_cnt = i_cfg.take_timeout_ms; n_run = 1'b1; n_to = 1'b0;
                    end
                end
                PH_TAKE_WAIT: begin
                    if (!i_out_ok) begin
                        take_ev = 1'b1;
                        n_cnt = i_low ? i_cfg.low_stock_wait_ms : i_cfg.normal_wait_ms;
                        n_run = 1'b1; n_to = 1'b0;
                    end
                end
                PH_CALLBACK: begin
                    n_drive.callback = 1'b1;
                    cb_ev = 1'b1;
                    n_cnt = i_cfg.callback_pulse_ms; n_run = 1'b1; n_to = 1'b0;
                end
                PH_CALLBACK_WAIT: begin
                    if (tk_to) n_drive.callback = 1'b0;
                end
                PH_ERROR: begin
                    if (tk_to && i_fault) begin
                        n_cnt = i_cfg.error_check_ms; n_run = 1'b1; n_to = 1'b0;
                    end
                end
                default: begin
                    n_cnt = tk_cnt;
                end
            endcase
        end else if (i_cmd.payout) begin
            n_pend = 1'b1;
        end else if (i_cmd.force_idle) begin
            n_pend = 1'b0;
            n_run  = 1'b0;
            n_to   = 1'b0;
        end
    end

    // unit state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
            r_run   <= 1'b0;
            r_to    <= 1'b0;
            r_pend  <= 1'b0;
            r_drive <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_run   <= n_run;
            r_to    <= n_to;
            r_pend  <= n_pend;
            r_drive <= n_drive;
        end
    end

    // state as it stands after this transfer
    assign o_view.phase       = n_phase;
    assign o_view.drive       = n_drive;
    assign o_view.take_ev     = take_ev;
    assign o_view.callback_ev = cb_ev;

endmodule

>>> hw/rtl/dual_card_dispenser_sequencer_top.sv
// Path: an item is held in the input register; its result is captured in the result
// register when the item transfers, which waits while a held result is not taken.
// Throughput: one item per cycle while the result register is not held by i_out_ready low;
// both dispenser units update on the transfer between the two registers.
// Reset: synchronous active low; both units idle, timers stopped, drive lines low,
// configuration back to its default millisecond values.
// ----------------------------------------------------------------------------
// Dual card dispenser sequencer top level
// Input stage, two unit sequencers, query logic and result register
// ----------------------------------------------------------------------------
`include "dual_card_dispenser_sequencer_top_macros.svh"

module dual_card_dispenser_sequencer_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  dcds_pkg::t_ms        i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  dcds_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output dcds_pkg::t_out_item  o_out_data
);
    import dcds_pkg::*;

    logic       r_in_valid;
    t_in_item   r_in;
    logic       r_out_valid;
    t_out_item  r_out;
    t_out_item  n_out;

    logic       fire;
    t_cfg       cfg;
    t_cmd       cmd;
    t_unit_cmd  ucmd_a;
    t_unit_cmd  ucmd_b;
    t_unit_view view_a;
    t_unit_view view_b;
    logic       avail_a;
    logic       avail_b;
    logic       is_query;

    // pipeline handshake
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // configuration registers
    dcds_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // command decode per unit
    assign cmd = t_cmd'(r_in.cmd);

    always_comb begin
        ucmd_a.tick       = (cmd == CMD_TICK);
        ucmd_a.prepare    = (cmd == CMD_PREPARE)   && !r_in.unit;
        ucmd_a.payout     = (cmd == CMD_PAYOUT)    && !r_in.unit;
        ucmd_a.callback   = (cmd == CMD_CALLBACK)  && !r_in.unit;
        ucmd_a.reset_all  = (cmd == CMD_RESET_ALL);
        ucmd_a.force_idle = (cmd == CMD_RESET_ONE) && !r_in.unit;
        ucmd_b.tick       = (cmd == CMD_TICK);
        ucmd_b.prepare    = (cmd == CMD_PREPARE)   && r_in.unit;
        ucmd_b.payout     = (cmd == CMD_PAYOUT)    && r_in.unit;
        ucmd_b.callback   = (cmd == CMD_CALLBACK)  && r_in.unit;
        ucmd_b.reset_all  = (cmd == CMD_RESET_ALL);
        ucmd_b.force_idle = (cmd == CMD_RESET_ONE) && r_in.unit;
    end

    // unit sequencers
    dcds_unit u_unit_a (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_cmd    (ucmd_a),
        .i_cfg    (cfg),
        .i_fault  (r_in.fault_a),
        .i_low    (r_in.low_a),
        .i_out_ok (r_in.out_ok_a),
        .o_view   (view_a)
    );

    dcds_unit u_unit_b (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_cmd    (ucmd_b),
        .i_cfg    (cfg),
        .i_fault  (r_in.fault_b),
        .i_low    (r_in.low_b),
        .i_out_ok (r_in.out_ok_b),
        .o_view   (view_b)
    );

    // first available unit
    assign is_query = (cmd == CMD_QUERY);
    assign avail_a  = !r_in.empty_a && !r_in.fault_a;
    assign avail_b  = !r_in.empty_b && !r_in.fault_b;

    // result assembly
    always_comb begin
        n_out.phase_a             = view_a.phase;
        n_out.phase_b             = view_b.phase;
        n_out.drive_payout        = {view_b.drive.payout,   view_a.drive.payout};
        n_out.drive_reset         = {view_b.drive.reset,    view_a.drive.reset};
        n_out.drive_callback      = {view_b.drive.callback, view_a.drive.callback};
        n_out.take_card_event     = {view_b.take_ev,        view_a.take_ev};
        n_out.callback_card_event = {view_b.callback_ev,    view_a.callback_ev};
        n_out.available           = is_query && (avail_a || avail_b);
        n_out.avail_unit          = is_query && !avail_a && avail_b;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // assertions
    `DCDS_ASSERT_SAME(a_ready_when_out_empty, i_clk, i_rst_n, !r_out_valid, o_in_ready, "input stalled with empty result register")
    `DCDS_ASSERT_NEXT(a_events_only_on_tick, i_clk, i_rst_n, fire && (cmd != CMD_TICK), (o_out_data.take_card_event == 2'b00) && (o_out_data.callback_card_event == 2'b00), "event reported on a non-tick transfer")
    `DCDS_ASSERT_NEXT(a_avail_only_on_query, i_clk, i_rst_n, fire && (cmd != CMD_QUERY), !o_out_data.available && !o_out_data.avail_unit, "availability reported on a non-query transfer")

endmodule
